// File: hw/rtl/snf_pkg.sv
// shared types, constants and lookup functions for the spectral noise filler
package snf_pkg;

    localparam int COEFF_W     = 16;
    localparam int IDX_W       = 9;
    localparam int CNT_W       = 9;
    localparam int SEED_W      = 16;
    localparam int LEVEL_W     = 4;
    localparam int NF_W        = 3;
    localparam int BW_W        = 3;
    localparam int DUR_W       = 2;
    localparam int WIN_W       = 2;
    localparam int START_W     = 5;
    localparam int RUN_W       = 3;
    localparam int POS_W       = IDX_W + 1;
    localparam int DLY_DEPTH   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;

    // request kinds carried on s_tuser
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_COEFF  = 1'b1;

    // frame durations
    localparam logic [DUR_W-1:0] DUR_10MS  = 2'd0;
    localparam logic [DUR_W-1:0] DUR_7MS5  = 2'd1;
    localparam logic [DUR_W-1:0] DUR_5MS   = 2'd2;
    localparam logic [DUR_W-1:0] DUR_2MS5  = 2'd3;

    localparam logic [RUN_W-1:0]   RUN_MAX    = 3'd7;
    localparam logic [SEED_W-1:0]  LCG_ADD    = 16'd13849;
    localparam logic [SEED_W-1:0]  LCG_MUL    = 16'd31821;
    localparam logic [LEVEL_W-1:0] LEVEL_BASE = 4'd8;
    localparam logic [BW_W-1:0]    BW_FULL    = 3'd4;

    localparam logic [IDX_W-1:0] STOP_TABLE [5] = '{9'd80, 9'd160, 9'd240, 9'd320, 9'd400};

    typedef struct packed {
        logic                      is_header;
        logic                      last;
        logic                      is_zero;
        logic [COEFF_W-1:0]        coeff;
        logic [LEVEL_W-1:0]        level;
        logic [IDX_W-1:0]          stop;
        logic [SEED_W-1:0]         seed;
        logic                      skip;
        logic [CNT_W-1:0]          count;
    } snf_entry_t;

    // half window of the zero test
    function automatic logic [WIN_W-1:0] win_of(input logic [DUR_W-1:0] dur);
        logic [WIN_W-1:0] w;
        case (dur)
            DUR_10MS: w = 2'd3;
            DUR_7MS5: w = 2'd2;
            default:  w = 2'd1;
        endcase
        return w;
    endfunction

    // fill start minus half window: below this the zero run is held cleared
    function automatic logic [START_W-1:0] start_less_win(input logic [DUR_W-1:0] dur);
        logic [START_W-1:0] s;
        case (dur)
            DUR_10MS: s = 5'd21;
            DUR_7MS5: s = 5'd16;
            DUR_5MS:  s = 5'd11;
            default:  s = 5'd5;
        endcase
        return s;
    endfunction

    // bandwidth stop scaled to the frame duration
    function automatic logic [IDX_W-1:0] stop_of(input logic [BW_W-1:0] bw,
                                                 input logic [DUR_W-1:0] dur);
        logic [IDX_W-1:0] base;
        logic [IDX_W+1:0] tri_sum;
        logic [IDX_W-1:0] s;
        base    = (bw > BW_FULL) ? STOP_TABLE[BW_FULL] : STOP_TABLE[bw];
        tri_sum = {2'b00, base} + {1'b0, base, 1'b0};
        case (dur)
            DUR_7MS5: s = tri_sum[IDX_W+1:2];
            DUR_5MS:  s = {1'b0, base[IDX_W-1:1]};
            DUR_2MS5: s = {2'b00, base[IDX_W-1:2]};
            default:  s = base;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/snf_front.sv
// input decode: unpacks a request and classifies it for the queue
module snf_front
    import snf_pkg::*;
(
    input  logic [DUR_W-1:0]     frame_duration,
    input  logic                 kind,
    input  logic [S_TDATA_W-1:0] data,
    input  logic                 last,
    output snf_entry_t           entry
);

    logic [COEFF_W-1:0] coeff;
    logic [NF_W-1:0]    noise_factor;
    logic [BW_W-1:0]    bandwidth;

    assign coeff        = data[15:0];
    assign noise_factor = data[18:16];
    assign bandwidth    = data[21:19];

    always_comb
    begin
        entry.is_header = (kind == KIND_HEADER);
        entry.last      = last;
        entry.is_zero   = (coeff == '0);
        entry.coeff     = coeff;
        entry.level     = LEVEL_BASE - {1'b0, noise_factor};
        entry.stop      = stop_of(bandwidth, frame_duration);
        entry.seed      = data[37:22];
        entry.skip      = data[38];
        entry.count     = data[47:39];
    end

endmodule

// File: hw/rtl/snf_queue.sv
// short request queue between decode and the fill engine
module snf_queue
    import snf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  snf_entry_t push_entry,
    input  logic       pop,
    output snf_entry_t head,
    output logic       not_empty,
    output logic       not_full
);

    snf_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/snf_back.sv
// fill engine: zero run, noise generator, delay line, flush and output register
module snf_back
    import snf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DUR_W-1:0]     frame_duration,
    input  snf_entry_t           head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [SEED_W-1:0]   noise_reg, noise_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [COEFF_W-1:0]  dly_reg [DLY_DEPTH];
    logic [COEFF_W-1:0]  dly_next [DLY_DEPTH];
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    lf_reg, lf_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]    stop_reg, stop_next;
    logic                skip_reg, skip_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WIN_W-1:0]    flush_left_reg, flush_left_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic [WIN_W-1:0]    w;
    logic [START_W-1:0]  start_w;
    logic                flushing;
    logic                coeff_here;
    logic                hdr_here;
    logic                active;
    logic [POS_W-1:0]    mv;
    logic                step_zero;
    logic [COEFF_W-1:0]  shift_in;
    logic [RUN_W-1:0]    run_step;
    logic                emits;
    logic [IDX_W-1:0]    k;
    logic                fill;
    logic [2*SEED_W-1:0] lcg_prod;
    logic [SEED_W-1:0]   lcg;
    logic [COEFF_W-1:0]  level_ext;
    logic [COEFF_W-1:0]  fill_val;
    logic [COEFF_W-1:0]  value;
    logic [IDX_W-1:0]    lf_step;
    logic                final_step;
    logic [IDX_W:0]      lf_inc;
    logic [CNT_W-1:0]    lnz;
    logic                out_free;
    logic                go;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // one step: either a real coefficient or a flush position after the last one
    always_comb
    begin
        w          = win_of(frame_duration);
        start_w    = start_less_win(frame_duration);
        flushing   = (state_reg == ST_FLUSH);
        coeff_here = (state_reg == ST_RUN) && head_valid && !head.is_header;
        hdr_here   = (state_reg == ST_RUN) && head_valid && head.is_header;
        active     = flushing || coeff_here;
        mv         = flushing ? pos_reg : {1'b0, pos_reg[IDX_W-1:0]};
        step_zero  = flushing ? 1'b1 : head.is_zero;
        shift_in   = flushing ? '0 : head.coeff;

        if (mv < POS_W'(start_w))
        begin
            run_step = '0;
        end
        else if ((mv >= {1'b0, stop_reg}) || step_zero)
        begin
            run_step = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 1'b1;
        end
        else
        begin
            run_step = '0;
        end

        emits     = (mv >= POS_W'(w));
        k         = IDX_W'(mv - POS_W'(w));
        fill      = emits && !skip_reg && (run_step > {w, 1'b0}) && (k < stop_reg);
        lcg_prod  = (2*SEED_W)'(noise_reg) * (2*SEED_W)'(LCG_MUL);
        lcg       = lcg_prod[SEED_W-1:0] + LCG_ADD;
        level_ext = COEFF_W'(level_reg);
        fill_val  = lcg[SEED_W-1] ? ('0 - level_ext) : level_ext;
        value     = fill ? fill_val : dly_reg[w - 1'b1];
        lf_step   = fill ? k : lf_reg;

        final_step = flushing && (flush_left_reg == WIN_W'(1));
        lf_inc     = {1'b0, lf_step} + 1'b1;
        if (skip_reg)
        begin
            lnz = cnt_reg;
        end
        else
        begin
            lnz = (lf_inc > {1'b0, cnt_reg}) ? lf_inc[IDX_W-1:0] : cnt_reg;
        end

        out_free = !m_valid_reg || m_tready;
        go       = active && (!emits || out_free);
        pop      = hdr_here || (coeff_here && go);
    end

    always_comb
    begin
        state_next      = state_reg;
        noise_next      = noise_reg;
        run_next        = run_reg;
        dly_next        = dly_reg;
        pos_next        = pos_reg;
        lf_next         = lf_reg;
        level_next      = level_reg;
        stop_next       = stop_reg;
        skip_next       = skip_reg;
        cnt_next        = cnt_reg;
        flush_left_next = flush_left_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (hdr_here)
        begin
            stop_next  = head.stop;
            level_next = head.level;
            noise_next = head.seed;
            skip_next  = head.skip;
            cnt_next   = head.count;
            pos_next   = '0;
            run_next   = '0;
            lf_next    = '0;
            for (int i = 0; i < DLY_DEPTH; i++)
            begin
                dly_next[i] = '0;
            end
        end
        else if (go)
        begin
            run_next = run_step;
            lf_next  = lf_step;
            if (fill)
            begin
                noise_next = lcg;
            end
            for (int i = DLY_DEPTH - 1; i > 0; i--)
            begin
                dly_next[i] = dly_reg[i-1];
            end
            dly_next[0] = shift_in;
            pos_next    = mv + 1'b1;

            if (emits)
            begin
                m_valid_next = 1'b1;
                m_data_next  = {(M_TDATA_W - COEFF_W - IDX_W - CNT_W)'(0),
                                final_step ? lnz : CNT_W'(0), k, value};
                m_last_next  = final_step;
            end

            if (coeff_here && head.last)
            begin
                state_next      = ST_FLUSH;
                flush_left_next = w;
            end
            else if (flushing)
            begin
                flush_left_next = flush_left_reg - 1'b1;
                if (final_step)
                begin
                    state_next = ST_RUN;
                    pos_next   = '0;
                    run_next   = '0;
                    lf_next    = '0;
                    for (int i = 0; i < DLY_DEPTH; i++)
                    begin
                        dly_next[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            noise_reg      <= '0;
            run_reg        <= '0;
            for (int i = 0; i < DLY_DEPTH; i++)
            begin
                dly_reg[i] <= '0;
            end
            pos_reg        <= '0;
            lf_reg         <= '0;
            level_reg      <= '0;
            stop_reg       <= '0;
            skip_reg       <= 1'b0;
            cnt_reg        <= '0;
            flush_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            noise_reg      <= noise_next;
            run_reg        <= run_next;
            dly_reg        <= dly_next;
            pos_reg        <= pos_next;
            lf_reg         <= lf_next;
            level_reg      <= level_next;
            stop_reg       <= stop_next;
            skip_reg       <= skip_next;
            cnt_reg        <= cnt_next;
            flush_left_reg <= flush_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/spectral_noise_filler_top.sv
// top level of the spectral noise filler: config register, decode, queue, fill engine
//
// usage
//  - s_* carries requests: s_tuser 0 is a frame header, 1 a spectral coefficient;
//    s_tlast marks the final coefficient of a frame
//  - m_* carries the filled coefficients in order, with their index; m_tlast marks
//    the final result of a frame, which alone carries the updated last-nonzero count
//  - cfg_* writes the frame duration; cfg_ready is always high, write only while idle
// throughput and ordering
//  - one request per cycle into a four-entry queue while not full; headers and
//    ordinary coefficients leave it one a cycle unless the engine output stalls
//  - a final coefficient is followed by a flush of the delay line over w positions
//    (w = 3, 2, 1, 1 by duration)
//  - a result passes through the queue, the engine and the output register, and
//    results run w coefficients behind the input
// reset and stalls
//  - rst_n clears the queue, generator, delay line, header state and duration
//  - when m_tready is low the engine holds, the queue fills, and s_tready drops
//    once it is full; nothing is lost or repeated
module spectral_noise_filler_top
    import snf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DUR_W-1:0]     cfg_data,     // frame_duration
    // request stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] coeff, [18:16] noise_factor, [21:19] bandwidth, [37:22] seed,
    // [38] zero_frame, [47:39] last_nonzero_in
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,      // [0] action
    input  logic                 s_tlast,      // last_coeff
    // result stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] coeff_out, [24:16] coeff_index, [33:25] last_nonzero_out, [39:34] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast       // is_last
);

    logic [DUR_W-1:0] dur_reg;
    snf_entry_t       dec_entry;
    snf_entry_t       head;
    logic             head_valid;
    logic             q_not_full;
    logic             pop;

    // duration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= DUR_10MS;
        end
        else if (cfg_valid)
        begin
            dur_reg <= cfg_data;
        end
    end

    // decode: header fields are resolved here (stop, level) so the engine stays short
    snf_front u_front (
        .frame_duration (dur_reg),
        .kind           (s_tuser),
        .data           (s_tdata),
        .last           (s_tlast),
        .entry          (dec_entry)
    );

    // queue lets the input keep flowing while the engine flushes or the output stalls
    assign s_tready = q_not_full;

    snf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (dec_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (head_valid),
        .not_full   (q_not_full)
    );

    // fill engine with its own output register
    snf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_duration (dur_reg),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

// File: tb/sv/tb_spectral_noise_filler_top.sv
// testbench for the spectral noise filler: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_spectral_noise_filler_top;
    import snf_pkg::*;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for the pressure test
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 20;    // queue plus flush plus output register, with margin

    typedef struct {
        logic [COEFF_W-1:0] coeff;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   lnz;
        logic               last;
    } filled_coeff_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [DUR_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    spectral_noise_filler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // expected filled coefficients, oldest first
    filled_coeff_t expected_coeffs[$];
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            hold_requests  = 0;

    // predictor state
    logic [DUR_W-1:0]   duration_reg = DUR_10MS;
    logic [SEED_W-1:0]  noise_lcg    = '0;
    logic [RUN_W-1:0]   zero_len     = '0;
    logic [COEFF_W-1:0] held_coeff [DLY_DEPTH] = '{default: '0};
    logic [IDX_W-1:0]   slot         = '0;
    logic [IDX_W-1:0]   fill_last    = '0;
    logic [LEVEL_W-1:0] fill_level   = '0;
    logic [IDX_W-1:0]   band_stop    = '0;
    logic               pass_through = 1'b0;
    logic [CNT_W-1:0]   lnz_base     = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int half_window(logic [DUR_W-1:0] dur);
        case (dur)
            DUR_10MS: return 3;
            DUR_7MS5: return 2;
            default:  return 1;
        endcase
    endfunction

    function automatic int fill_start(logic [DUR_W-1:0] dur);
        case (dur)
            DUR_10MS: return 24;
            DUR_7MS5: return 18;
            DUR_5MS:  return 12;
            default:  return 6;
        endcase
    endfunction

    function automatic void predict_header(logic [S_TDATA_W-1:0] data);
        int bw;
        int stop;
        bw   = int'(data[21:19]);
        stop = (bw > int'(BW_FULL)) ? 400 : 80 * (bw + 1);
        case (duration_reg)
            DUR_7MS5: stop = (stop * 3) >> 2;
            DUR_5MS:  stop = stop >> 1;
            DUR_2MS5: stop = stop >> 2;
            default:  ;
        endcase
        band_stop    = IDX_W'(stop);
        fill_level   = LEVEL_BASE - {1'b0, data[18:16]};
        noise_lcg    = data[37:22];
        pass_through = data[38];
        lnz_base     = data[47:39];
        slot         = '0;
        zero_len     = '0;
        fill_last    = '0;
        held_coeff   = '{default: '0};
    endfunction

    // zero run over the window: held cleared below start-w, counted as zero at or past stop
    function automatic void step_zero_len(int m, logic is_zero, int start, int w);
        if (m < start - w)
            zero_len = '0;
        else if (m >= int'(band_stop) || is_zero)
            zero_len = (zero_len < RUN_MAX) ? zero_len + 1'b1 : RUN_MAX;
        else
            zero_len = '0;
    endfunction

    function automatic filled_coeff_t noise_fill(int k, logic [COEFF_W-1:0] val, int w);
        filled_coeff_t r;
        r.coeff = val;
        if (!pass_through && int'(zero_len) > 2 * w && k < int'(band_stop))
        begin
            noise_lcg = LCG_ADD + noise_lcg * LCG_MUL;
            r.coeff   = noise_lcg[SEED_W-1] ? COEFF_W'(0) - COEFF_W'(fill_level)
                                            : COEFF_W'(fill_level);
            fill_last = IDX_W'(k);
        end
        r.index = IDX_W'(k);
        r.lnz   = '0;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic void predict_coefficient(logic [COEFF_W-1:0] c, logic last);
        int            w;
        int            start;
        int            m;
        int            lnz;
        filled_coeff_t r;
        w     = half_window(duration_reg);
        start = fill_start(duration_reg);
        m     = int'(slot);
        step_zero_len(m, c == '0, start, w);
        if (m >= w)
            expected_coeffs.push_back(noise_fill(m - w, held_coeff[w-1], w));
        held_coeff[2] = held_coeff[1];
        held_coeff[1] = held_coeff[0];
        held_coeff[0] = c;
        slot = slot + 1'b1;
        if (last)
        begin
            // flush the delay line; the final flush step always yields a result
            for (int j = 1; j <= w; j++)
            begin
                step_zero_len(m + j, 1'b1, start, w);
                if (m + j >= w)
                begin
                    r = noise_fill(m + j - w, held_coeff[w-j], w);
                    if (j == w)
                    begin
                        if (pass_through)
                            lnz = int'(lnz_base);
                        else
                            lnz = (int'(fill_last) + 1 > int'(lnz_base)) ? int'(fill_last) + 1
                                                                         : int'(lnz_base);
                        r.lnz  = CNT_W'(lnz);
                        r.last = 1'b1;
                    end
                    expected_coeffs.push_back(r);
                end
            end
            slot       = '0;
            zero_len   = '0;
            fill_last  = '0;
            held_coeff = '{default: '0};
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string what, longint want, longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        filled_coeff_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_coeffs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual index %0d value %0d",
                         $time, m_tdata[24:16], $signed(m_tdata[15:0]));
            end
            else
            begin
                want = expected_coeffs.pop_front();
                check_field("coeff_out", $signed(want.coeff), $signed(m_tdata[15:0]));
                check_field("coeff_index", want.index, m_tdata[24:16]);
                check_field("last_nonzero_out", want.lnz, m_tdata[33:25]);
                check_field("is_last", want.last, m_tlast);
                check_field("tdata padding", 0, m_tdata[39:34]);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : result_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial
    begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_request(logic kind, logic [S_TDATA_W-1:0] data, logic last);
        while (int'($urandom_range(0, 99)) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == KIND_HEADER)
            predict_header(data);
        else
            predict_coefficient(data[COEFF_W-1:0], last);
    endtask

    // coefficient bits of a header and tlast are don't-care, so they are randomised
    task automatic send_header(logic [NF_W-1:0] nf, logic [BW_W-1:0] bw,
                               logic [SEED_W-1:0] seed, logic zf, logic [CNT_W-1:0] lnz);
        send_request(KIND_HEADER, {lnz, zf, seed, bw, nf, COEFF_W'($urandom)},
                     1'($urandom_range(0, 1)));
    endtask

    // header bits of a coefficient request are don't-care
    task automatic send_coeff(logic [COEFF_W-1:0] c, logic last);
        send_request(KIND_COEFF, {32'($urandom), c}, last);
    endtask

    task automatic send_random_header();
        send_header(NF_W'($urandom_range(0, 7)), BW_W'($urandom_range(0, 7)),
                    SEED_W'($urandom), $urandom_range(0, 4) == 0,
                    CNT_W'($urandom_range(0, 511)));
    endtask

    function automatic logic [COEFF_W-1:0] random_coeff(int zero_pct);
        if (int'($urandom_range(0, 99)) < zero_pct)
            return '0;
        if ($urandom_range(0, 1))
            return $urandom_range(0, 1) ? COEFF_W'($urandom_range(1, 3))
                                        : COEFF_W'(0) - COEFF_W'($urandom_range(1, 3));
        return COEFF_W'($urandom);
    endfunction

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_coeffs.size() != 0)
            @(posedge clk);
        // headers and early coefficients give no result and may still be queued
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_duration(logic [DUR_W-1:0] dur);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= dur;
        do
            @(posedge clk);
        while (!cfg_ready);
        duration_reg = dur;
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames, some stray headers and headerless coefficients
    task automatic run_random_frames(int n_items);
        int sent;
        int len;
        int zero_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_random_header();
                sent++;
                len      = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                       : $urandom_range(1, 40);
                zero_pct = $urandom_range(50, 95);
                for (int i = 0; i < len; i++)
                    send_coeff(random_coeff(zero_pct), i == len - 1);
                sent += len;
            end
            else if ($urandom_range(0, 1))
            begin
                send_random_header();
                sent++;
            end
            else
            begin
                send_coeff(random_coeff(50), $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset state: stop is zero so nothing is filled
    task automatic test_before_header();
        send_coeff(COEFF_W'(5), 1'b0);
        send_coeff('0, 1'b1);
    endtask

    // coefficient extremes, then a zero tail long enough to be filled at full level
    task automatic test_fill_short_frame();
        write_duration(DUR_2MS5);
        send_header(NF_W'(0), BW_W'(0), 16'hFFFF, 1'b0, '0);
        send_coeff(16'h7FFF, 1'b0);
        send_coeff(16'h8000, 1'b0);
        for (int i = 2; i < 9; i++)
            send_coeff('0, i == 8);
    endtask

    // zero frame with saturated bandwidth: values pass through, count passes as given
    task automatic test_zero_frame();
        send_header(NF_W'(7), BW_W'(7), '0, 1'b1, 9'h1FF);
        for (int i = 0; i < 3; i++)
            send_coeff('0, i == 2);
    endtask

    // new start takes effect part way through the frame; the window stays the same
    task automatic test_duration_change();
        send_header(NF_W'(3), BW_W'(4), 16'h8000, 1'b0, '0);
        for (int i = 0; i < 5; i++)
            send_coeff('0, 1'b0);
        write_duration(DUR_5MS);
        send_coeff('0, 1'b0);
        send_coeff('0, 1'b1);
    endtask

    task automatic test_random_traffic(logic [DUR_W-1:0] dur, int src_pct, int sink_pct,
                                       int n_items);
        write_duration(dur);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        run_random_frames(n_items);
    endtask

    // receiver holds off while requests keep coming, so the queue fills and input stalls
    task automatic test_output_backpressure();
        write_duration(DUR_2MS5);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests++;
        for (int f = 0; f < 3; f++)
        begin
            send_random_header();
            for (int i = 0; i < 12; i++)
                send_coeff(random_coeff(85), i == 11);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_HEADER;
        s_tlast   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_header();
        test_fill_short_frame();
        test_zero_frame();
        test_duration_change();
        test_random_traffic(DUR_2MS5, 0, 0, 60);
        test_random_traffic(DUR_10MS, 73, 0, 60);
        test_random_traffic(DUR_7MS5, 0, 73, 60);
        test_random_traffic(DUR_5MS, 35, 35, 60);
        test_output_backpressure();
        wait_for_idle();

        if (mismatch_count == 0 && expected_coeffs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/snf_pkg.sv
hw/rtl/snf_front.sv
hw/rtl/snf_queue.sv
hw/rtl/snf_back.sv
hw/rtl/spectral_noise_filler_top.sv
tb/sv/tb_spectral_noise_filler_top.sv
